// ===== rtl/box5_pkg.sv =====
// ----------------------------------------------------------------------------
// box5_pkg
// Types and constants shared by the 5x5 mean filter.
// ----------------------------------------------------------------------------
package box5_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned ColW      = 11;
  localparam int unsigned RowW      = 12;
  localparam int unsigned CfgW      = 12;
  localparam int unsigned ColSumW   = 11;
  localparam int unsigned TotalW    = 13;
  localparam int unsigned LineW     = 32;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;

  localparam int unsigned WinTaps   = 5;
  localparam int unsigned Edge      = 2;
  localparam int unsigned HeightMax = 4095;

  // Division by 25: total * 5243 >> 17 is exact for totals below 6400.
  localparam int unsigned RecipMul   = 5243;
  localparam int unsigned RecipShift = 17;
  localparam int unsigned ProdW      = TotalW + 13;

  localparam logic [CfgW-1:0] WidthReset  = 12'd640;
  localparam logic [CfgW-1:0] HeightReset = 12'd480;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            emit;
    logic            last;
  } s1_t;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic              last;
  } s2_t;

endpackage

// ===== rtl/box_filter_5x5_mean.sv =====
// ----------------------------------------------------------------------------
// box_filter_5x5_mean
// 5x5 mean filter over a raster-order 8-bit frame, built around one line store.
// ----------------------------------------------------------------------------
// A result passes through the stage 1, stage 2 and output registers in order.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// single line-store read-modify-write per pixel, with forwarding where
// consecutive pixels hit the same entry.
// Reset clears the counters, the column-sum window, the pipeline and the
// registers; the line store is not cleared, and the first four rows of each
// frame produce no result.
module box_filter_5x5_mean #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [box5_pkg::PixW-1:0]       pixel_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [box5_pkg::PixW-1:0]       mean_out_o,
  output logic [box5_pkg::ColW-1:0]       out_col_o,
  output logic [box5_pkg::RowW-1:0]       out_row_o,
  output logic                            frame_last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [box5_pkg::ApbAddrW-1:0]   paddr,
  input  logic [box5_pkg::ApbDataW-1:0]   pwdata,
  output logic [box5_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  localparam int unsigned AddrW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WidthCap = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam logic [box5_pkg::CfgW-1:0] WidthCapL = box5_pkg::CfgW'(WidthCap);
  localparam logic [box5_pkg::CfgW-1:0] TapsL     = box5_pkg::CfgW'(box5_pkg::WinTaps);
  localparam logic [box5_pkg::CfgW-1:0] HeightCapL = box5_pkg::CfgW'(box5_pkg::HeightMax);

  // Configuration registers.
  logic [box5_pkg::CfgW-1:0] width_q, height_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= box5_pkg::WidthReset;
      height_q <= box5_pkg::HeightReset;
    end else if (cfg_wr) begin
      case (box5_pkg::cfg_reg_e'(paddr[2]))
        box5_pkg::CFG_WIDTH:  width_q  <= pwdata[box5_pkg::CfgW-1:0];
        box5_pkg::CFG_HEIGHT: height_q <= pwdata[box5_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (box5_pkg::cfg_reg_e'(paddr[2]))
      box5_pkg::CFG_WIDTH:  prdata = {{(box5_pkg::ApbDataW-box5_pkg::CfgW){1'b0}}, width_q};
      box5_pkg::CFG_HEIGHT: prdata = {{(box5_pkg::ApbDataW-box5_pkg::CfgW){1'b0}}, height_q};
      default:              prdata = '0;
    endcase
  end

  // Pipeline handshake.
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_rdy, s2_rdy, s1_go, s1_rdy, accept;
  box5_pkg::s1_t s1_q;
  box5_pkg::s2_t s2_q;

  assign out_rdy    = !out_v_q || !out_stall_i;
  assign s2_rdy     = !s2_v_q || out_rdy;
  assign s1_go      = s1_v_q && (s2_rdy || !s1_q.emit);
  assign s1_rdy     = !s1_v_q || s1_go;
  assign accept     = in_valid_i && s1_rdy;
  assign in_stall_o = !s1_rdy;

  // Stage 0: position counters and line-store read.
  logic [box5_pkg::ColW-1:0] col_q, col_d;
  logic [box5_pkg::RowW-1:0] row_q, row_d;
  logic [box5_pkg::CfgW-1:0] eff_w, eff_h;
  logic [box5_pkg::ColW:0]   col_inc;
  logic [box5_pkg::RowW:0]   row_inc;
  logic                      last_col, last_row;
  logic [AddrW-1:0]          rd_idx;
  box5_pkg::s1_t             s1_d;

  always_comb begin
    eff_w = width_q;
    if (width_q < TapsL) eff_w = TapsL;
    if (width_q > WidthCapL) eff_w = WidthCapL;
    eff_h = height_q;
    if (height_q < TapsL) eff_h = TapsL;
    if (height_q > HeightCapL) eff_h = HeightCapL;

    col_inc  = {1'b0, col_q} + 12'd1;
    row_inc  = {1'b0, row_q} + 13'd1;
    last_col = col_inc >= eff_w;
    last_row = row_inc >= {1'b0, eff_h};

    col_d = last_col ? '0 : col_inc[box5_pkg::ColW-1:0];
    row_d = row_q;
    if (last_col) row_d = last_row ? '0 : row_inc[box5_pkg::RowW-1:0];

    rd_idx = (32'(col_q) < MAX_WIDTH) ? AddrW'(col_q) : '0;

    s1_d.pixel = pixel_in_i;
    s1_d.col   = col_q - box5_pkg::ColW'(box5_pkg::Edge);
    s1_d.row   = row_q - box5_pkg::RowW'(box5_pkg::Edge);
    s1_d.emit  = (col_q >= box5_pkg::ColW'(2 * box5_pkg::Edge))
              && (row_q >= box5_pkg::RowW'(2 * box5_pkg::Edge));
    s1_d.last  = last_col && last_row;
  end

  // Line store: rows r-1..r-4 of each column, newest in the low byte.
  logic [box5_pkg::LineW-1:0] line_mem [MAX_WIDTH];
  logic [box5_pkg::LineW-1:0] rd_data_q, fwd_data_q, old_word, wr_data;
  logic                       fwd_q;
  logic [AddrW-1:0]           s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      line_mem[s1_idx_q] <= wr_data;
    end
    if (accept) begin
      rd_data_q <= line_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q       <= s1_d;
      s1_idx_q   <= rd_idx;
      fwd_data_q <= wr_data;
    end
  end

  // Stage 1: column sum, window and 5x5 total.
  logic [box5_pkg::ColSumW-1:0] win_q [4];
  logic [box5_pkg::ColSumW-1:0] col_sum;
  logic [box5_pkg::TotalW-1:0]  total;
  box5_pkg::s2_t                s2_d;

  always_comb begin
    old_word = fwd_q ? fwd_data_q : rd_data_q;
    wr_data  = {old_word[box5_pkg::LineW-box5_pkg::PixW-1:0], s1_q.pixel};
    col_sum  = box5_pkg::ColSumW'(s1_q.pixel) + box5_pkg::ColSumW'(old_word[7:0])
             + box5_pkg::ColSumW'(old_word[15:8]) + box5_pkg::ColSumW'(old_word[23:16])
             + box5_pkg::ColSumW'(old_word[31:24]);
    total    = box5_pkg::TotalW'(col_sum) + box5_pkg::TotalW'(win_q[0])
             + box5_pkg::TotalW'(win_q[1]) + box5_pkg::TotalW'(win_q[2])
             + box5_pkg::TotalW'(win_q[3]);
    s2_d.total = total;
    s2_d.col   = s1_q.col;
    s2_d.row   = s1_q.row;
    s2_d.last  = s1_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_q.emit) begin
      s2_q <= s2_d;
    end
  end

  // Stage 2: division by 25 into the output register.
  logic [box5_pkg::ProdW-1:0] prod;

  assign prod = box5_pkg::ProdW'(s2_q.total) * box5_pkg::ProdW'(box5_pkg::RecipMul);

  always_ff @(posedge clk_i) begin
    if (s2_v_q && out_rdy) begin
      mean_out_o   <= prod[box5_pkg::RecipShift +: box5_pkg::PixW];
      out_col_o    <= s2_q.col;
      out_row_o    <= s2_q.row;
      frame_last_o <= s2_q.last;
    end
  end

  assign out_valid_o = out_v_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      fwd_q   <= 1'b0;
      for (int i = 0; i < 4; i++) win_q[i] <= '0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        fwd_q <= s1_go && (s1_idx_q == rd_idx);
      end
      if (s1_go) begin
        win_q[3] <= win_q[2];
        win_q[2] <= win_q[1];
        win_q[1] <= win_q[0];
        win_q[0] <= col_sum;
      end
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_go && s1_q.emit;
      if (out_rdy) out_v_q <= s2_v_q;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q)
    else $error("accepted pixel did not reach the line-store stage");

  a_empty_front_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> !in_stall_o)
    else $error("input stalled with an empty front stage");

  a_s2_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_q.col >= box5_pkg::ColW'(box5_pkg::Edge))
            && (s2_q.row >= box5_pkg::RowW'(box5_pkg::Edge)))
    else $error("border position reached the divider stage");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> s2_q.total <= box5_pkg::TotalW'(6375))
    else $error("5x5 total out of range");
`endif

endmodule
